// ----- src/assert_macros.svh -----
// Concurrent assertion macros shared by the RTL, empty for synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clock edge outside reset.
`define RMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("assertion failed");

// Check that the consequent holds in the cycle after the antecedent.
`define RMP_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define RMP_ASSERT(label, prop)
`define RMP_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ----- src/rmp_pkg.sv -----
// Types and constants of the RGB matrix PWM scanner.
package rmp_pkg;

  localparam int unsigned IDX_W      = 6;
  localparam int unsigned FRAME_AW   = 7;
  localparam int unsigned FRAME_DEPTH = 128;
  localparam int unsigned PAL_MAX    = 64;
  localparam int unsigned MASK_COUNT = 6;
  localparam int unsigned CH_COUNT   = 3;

  // Scan sequencer: one row issued per step, palette entries arrive through the frame store and palette read registers.
  localparam logic [3:0] READ_LAT  = 4'd2;
  localparam logic [3:0] SCAN_LAST = 4'd9;

  typedef enum logic [1:0] {
    MODE_TICK    = 2'd0,
    MODE_PIXEL   = 2'd1,
    MODE_PALETTE = 2'd2
  } mode_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_HOLD
  } scan_state_e;

  typedef struct packed {
    logic [1:0] mode;
    logic       matrix_sel;
    logic [2:0] col_addr;
    logic [2:0] row_addr;
    logic [5:0] color_index;
    logic [1:0] r_lvl;
    logic [1:0] g_lvl;
    logic [1:0] b_lvl;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red_mask_a;
    logic [7:0] green_mask_a;
    logic [7:0] blue_mask_a;
    logic [7:0] red_mask_b;
    logic [7:0] green_mask_b;
    logic [7:0] blue_mask_b;
    logic [2:0] active_col;
    logic       col_advance;
    logic       col_start_bit;
  } out_item_t;

  typedef struct packed {
    logic                frm_we;
    logic [FRAME_AW-1:0] frm_addr;
    logic [IDX_W-1:0]    frm_data;
    logic                pal_we;
    logic [IDX_W-1:0]    pal_idx;
    logic [5:0]          pal_data;
  } store_wr_t;

  typedef struct packed {
    logic [2:0] col;
    logic [2:0] row;
  } store_rd_t;

endpackage

// ----- src/rgb_matrix_pwm_scanner.sv -----
// Top level of the two-matrix RGB PWM scanner.
//
// Pixel writes, palette writes, unused modes and the tick at the top PWM count
// are taken without stalling the input and return nothing. Every other tick
// stalls the input until its masks are loaded: the sequencer walks the eight
// rows of the active column, one row a cycle, through the registered frame
// store and palette reads, and the compare logic clears the mask bits of the
// LEDs of both matrices whose level equals the PWM count. The masks
// then sit in the output register; the next item may be taken while they wait.
// Frame store and palette read as zero until written, tracked by valid bits, so
// no clearing pass follows reset.
`include "assert_macros.svh"

module rgb_matrix_pwm_scanner import rmp_pkg::*; #(
  parameter int unsigned LEVEL_MAX       = 3,
  parameter int unsigned COLUMN_COUNT    = 8,
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_o
);

  localparam int unsigned CW = $clog2(LEVEL_MAX + 1);
  localparam int unsigned LW = (CW > 2) ? CW : 2;
  localparam logic [CW-1:0] CNT_TOP = CW'(LEVEL_MAX);
  localparam logic [3:0]    COL_LIM = 4'(COLUMN_COUNT);

  scan_state_e state_q, state_d;
  logic [3:0]  step_q, step_d;
  logic [CW-1:0] cnt_q, cnt_d, cmp_q, cmp_d;
  logic [2:0]  col_q, col_d;
  logic        adv_q, adv_d, start_q, start_d;
  logic [MASK_COUNT-1:0][7:0] masks_q, masks_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic        in_acc, tick_go, out_free, step_last;
  logic        cmp_en, out_load;
  logic [3:0]  col_inc;
  logic [2:0]  cmp_row;
  logic [5:0]  ent_a, ent_b;
  store_wr_t   st_wr;
  store_rd_t   st_rd;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign tick_go   = in_acc && (in_i.mode == MODE_TICK) && (cnt_q < CNT_TOP);
  assign out_free  = !out_valid_q || !out_stall_i;
  assign step_last = (step_q == SCAN_LAST);
  assign col_inc   = {1'b0, col_q} + 4'd1;
  assign cmp_row   = 3'(step_q - READ_LAT);

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (tick_go) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (step_last) state_d = out_free ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_stall_o = 1'b1;
    cmp_en     = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
      end
      ST_SCAN: begin
        cmp_en   = (step_q >= READ_LAT);
        out_load = step_last && out_free;
      end
      ST_HOLD: begin
        out_load = out_free;
      end
      default: in_stall_o = 1'b1;
    endcase
  end

  // Memory write port and row read requests.
  always_comb begin
    st_wr.frm_we   = in_acc && (in_i.mode == MODE_PIXEL);
    st_wr.frm_addr = {in_i.matrix_sel, in_i.col_addr, in_i.row_addr};
    st_wr.frm_data = in_i.color_index;
    st_wr.pal_we   = in_acc && (in_i.mode == MODE_PALETTE);
    st_wr.pal_idx  = in_i.color_index;
    st_wr.pal_data = {in_i.b_lvl, in_i.g_lvl, in_i.r_lvl};
    st_rd.col      = col_q;
    st_rd.row      = step_q[2:0];
  end

  rmp_store #(
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) u_store (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .wr_i   (st_wr),
    .rd_i   (st_rd),
    .ent_a_o(ent_a),
    .ent_b_o(ent_b)
  );

  // Tick bookkeeping, row compare and result register.
  always_comb begin
    step_d      = step_q;
    cnt_d       = cnt_q;
    cmp_d       = cmp_q;
    col_d       = col_q;
    adv_d       = adv_q;
    start_d     = start_q;
    masks_d     = masks_q;
    out_valid_d = out_valid_q;
    out_d       = out_q;

    if (in_acc && (in_i.mode == MODE_TICK)) begin
      // Top count: wrap, no scan.
      cnt_d = (cnt_q >= CNT_TOP) ? '0 : cnt_q + CW'(1);
    end

    if (tick_go) begin
      step_d  = '0;
      cmp_d   = cnt_q;
      adv_d   = 1'b0;
      start_d = 1'b0;
      if (cnt_q == '0) begin
        adv_d   = 1'b1;
        masks_d = '1;
        if (col_inc >= COL_LIM) begin
          col_d   = '0;
          start_d = 1'b1;
        end else begin
          col_d = col_inc[2:0];
        end
      end
    end

    if (state_q == ST_SCAN && !step_last) begin
      step_d = step_q + 4'd1;
    end

    if (cmp_en) begin
      for (int ch = 0; ch < CH_COUNT; ch++) begin
        if (LW'(ent_a[2*ch +: 2]) == LW'(cmp_q)) masks_d[ch][cmp_row] = 1'b0;
        if (LW'(ent_b[2*ch +: 2]) == LW'(cmp_q)) masks_d[CH_COUNT + ch][cmp_row] = 1'b0;
      end
    end

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d         = 1'b1;
      out_d.red_mask_a    = masks_d[0];
      out_d.green_mask_a  = masks_d[1];
      out_d.blue_mask_a   = masks_d[2];
      out_d.red_mask_b    = masks_d[3];
      out_d.green_mask_b  = masks_d[4];
      out_d.blue_mask_b   = masks_d[5];
      out_d.active_col    = col_q;
      out_d.col_advance   = adv_q;
      out_d.col_start_bit = start_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      cnt_q       <= '0;
      col_q       <= '0;
      masks_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      cnt_q       <= cnt_d;
      col_q       <= col_d;
      masks_q     <= masks_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmp_q   <= cmp_d;
    adv_q   <= adv_d;
    start_q <= start_d;
    out_q   <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  `RMP_ASSERT(a_step_range, (state_q != ST_SCAN) || (step_q <= SCAN_LAST))
  `RMP_ASSERT(a_cnt_range, cnt_q <= CNT_TOP)
  `RMP_ASSERT(a_col_range, COL_LIM > 4'(col_q))
  `RMP_ASSERT_NEXT(a_scan_start, tick_go, (state_q == ST_SCAN) && (step_q == '0))

endmodule

// ----- src/rmp_store.sv -----
// Frame store and palette memories with a two-stage row read pipeline.
module rmp_store import rmp_pkg::*; #(
  parameter int unsigned PALETTE_ENTRIES = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  store_wr_t  wr_i,
  input  store_rd_t  rd_i,
  output logic [5:0] ent_a_o,
  output logic [5:0] ent_b_o
);

  localparam int unsigned PAL_DEPTH = (PALETTE_ENTRIES > PAL_MAX) ? PAL_MAX : PALETTE_ENTRIES;
  localparam int unsigned PAL_AW    = (PAL_DEPTH > 1) ? $clog2(PAL_DEPTH) : 1;
  localparam logic [IDX_W:0] PAL_LIM = (IDX_W + 1)'(PAL_DEPTH);

  logic [IDX_W-1:0]       frm_mem_q [FRAME_DEPTH];
  logic [FRAME_DEPTH-1:0] frm_vld_q;
  logic [5:0]             pal_mem_q [PAL_DEPTH];
  logic [PAL_DEPTH-1:0]   pal_vld_q;

  logic [FRAME_AW-1:0] addr_a, addr_b;
  logic [IDX_W-1:0]    fd_a_q, fd_b_q;
  logic                fv_a_q, fv_b_q;
  logic [IDX_W-1:0]    idx_a, idx_b;
  logic                in_a, in_b, pal_wr_ok;
  logic [PAL_AW-1:0]   pa_a, pa_b;
  logic [5:0]          pe_a_q, pe_b_q;
  logic                pv_a_q, pv_b_q;

  assign addr_a = {1'b0, rd_i.col, rd_i.row};
  assign addr_b = {1'b1, rd_i.col, rd_i.row};

  // Unwritten entries read as zero.
  assign idx_a = fv_a_q ? fd_a_q : '0;
  assign idx_b = fv_b_q ? fd_b_q : '0;
  assign in_a  = ({1'b0, idx_a} < PAL_LIM);
  assign in_b  = ({1'b0, idx_b} < PAL_LIM);
  assign pa_a  = idx_a[PAL_AW-1:0];
  assign pa_b  = idx_b[PAL_AW-1:0];

  assign pal_wr_ok = wr_i.pal_we && ({1'b0, wr_i.pal_idx} < PAL_LIM);

  always_ff @(posedge clk_i) begin
    if (wr_i.frm_we) begin
      frm_mem_q[wr_i.frm_addr] <= wr_i.frm_data;
    end
    fd_a_q <= frm_mem_q[addr_a];
    fd_b_q <= frm_mem_q[addr_b];
    fv_a_q <= frm_vld_q[addr_a];
    fv_b_q <= frm_vld_q[addr_b];
  end

  always_ff @(posedge clk_i) begin
    if (pal_wr_ok) begin
      pal_mem_q[wr_i.pal_idx[PAL_AW-1:0]] <= wr_i.pal_data;
    end
    pe_a_q <= pal_mem_q[pa_a];
    pe_b_q <= pal_mem_q[pa_b];
    pv_a_q <= pal_vld_q[pa_a] && in_a;
    pv_b_q <= pal_vld_q[pa_b] && in_b;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frm_vld_q <= '0;
      pal_vld_q <= '0;
    end else begin
      if (wr_i.frm_we) begin
        frm_vld_q[wr_i.frm_addr] <= 1'b1;
      end
      if (pal_wr_ok) begin
        pal_vld_q[wr_i.pal_idx[PAL_AW-1:0]] <= 1'b1;
      end
    end
  end

  assign ent_a_o = pv_a_q ? pe_a_q : '0;
  assign ent_b_o = pv_b_q ? pe_b_q : '0;

endmodule

// ----- sim/rgb_matrix_pwm_scanner_tb.sv -----
// Self-checking testbench of the two-matrix RGB PWM scanner with a PWM mask predictor.
module rgb_matrix_pwm_scanner_tb;
  import rmp_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LEVEL_MAX       = 3;
  localparam int unsigned COLUMN_COUNT    = 8;
  localparam int unsigned PALETTE_ENTRIES = 64;
  localparam logic [1:0]  MODE_UNUSED     = 2'd3;
  localparam int unsigned ITEM_COUNT      = 2000;
  localparam int unsigned LONG_HOLD       = 300;

  typedef struct {
    in_item_t    item;
    int unsigned reps;
    bit          typed;
    out_item_t   res;
  } dir_row_t;

  logic      clk_i;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_o;

  // predictor state
  logic [5:0]  pix_idx [128];
  logic [5:0]  pal_lv [64];
  logic [7:0]  led_on [6];
  int unsigned pwm_cnt;
  int unsigned scan_col;

  out_item_t   mask_q [$];
  out_item_t   mask_want;
  dir_row_t    plan [$];
  int unsigned masks_seen;
  int unsigned burst_left;
  int          errors;
  bit          held;

  rgb_matrix_pwm_scanner #(
    .LEVEL_MAX      (LEVEL_MAX),
    .COLUMN_COUNT   (COLUMN_COUNT),
    .PALETTE_ENTRIES(PALETTE_ENTRIES)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_o      (out_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic bit predict_masks(input in_item_t it, output out_item_t res);
    int unsigned idx;
    logic [5:0]  lv;
    bit          adv;
    bit          start;
    res = '0;
    adv = 1'b0;
    start = 1'b0;
    case (it.mode)
      MODE_PIXEL: begin
        pix_idx[{it.matrix_sel, it.col_addr, it.row_addr}] = it.color_index;
        return 1'b0;
      end
      MODE_PALETTE: begin
        if (it.color_index < PALETTE_ENTRIES)
          pal_lv[it.color_index] = {it.b_lvl, it.g_lvl, it.r_lvl};
        return 1'b0;
      end
      MODE_TICK: ;
      default: return 1'b0;
    endcase
    // top count: LEDs stay as they are, count wraps
    if (pwm_cnt >= LEVEL_MAX) begin
      pwm_cnt = 0;
      return 1'b0;
    end
    if (pwm_cnt == 0) begin
      adv = 1'b1;
      scan_col = scan_col + 1;
      if (scan_col >= COLUMN_COUNT) begin
        scan_col = 0;
        start = 1'b1;
      end
      foreach (led_on[k]) led_on[k] = 8'hFF;
    end
    scan_col = scan_col & 7;
    for (int m = 0; m < 2; m++) begin
      for (int row = 0; row < 8; row++) begin
        idx = pix_idx[m * 64 + scan_col * 8 + row];
        lv = (idx < PALETTE_ENTRIES) ? pal_lv[idx] : 6'd0;
        for (int ch = 0; ch < 3; ch++) begin
          if (lv[2 * ch +: 2] == pwm_cnt) led_on[m * 3 + ch][row] = 1'b0;
        end
      end
    end
    res.red_mask_a    = led_on[0];
    res.green_mask_a  = led_on[1];
    res.blue_mask_a   = led_on[2];
    res.red_mask_b    = led_on[3];
    res.green_mask_b  = led_on[4];
    res.blue_mask_b   = led_on[5];
    res.active_col    = scan_col[2:0];
    res.col_advance   = adv;
    res.col_start_bit = start;
    pwm_cnt = pwm_cnt + 1;
    if (pwm_cnt > LEVEL_MAX) pwm_cnt = 0;
    return 1'b1;
  endfunction

  function automatic in_item_t mk_tick();
    in_item_t it;
    it = '0;
    it.mode = MODE_TICK;
    return it;
  endfunction

  function automatic in_item_t mk_pixel(bit m, logic [2:0] c, logic [2:0] r, logic [5:0] idx);
    in_item_t it;
    it = '0;
    it.mode = MODE_PIXEL;
    it.matrix_sel = m;
    it.col_addr = c;
    it.row_addr = r;
    it.color_index = idx;
    return it;
  endfunction

  function automatic in_item_t mk_palette(logic [5:0] idx, logic [1:0] rl, logic [1:0] gl,
                                          logic [1:0] bl);
    in_item_t it;
    it = '0;
    it.mode = MODE_PALETTE;
    it.color_index = idx;
    it.r_lvl = rl;
    it.g_lvl = gl;
    it.b_lvl = bl;
    return it;
  endfunction

  function automatic out_item_t mk_masks(logic [7:0] mask_a, logic [7:0] mask_b,
                                         logic [2:0] col, bit adv, bit start);
    out_item_t res;
    res.red_mask_a    = mask_a;
    res.green_mask_a  = mask_a;
    res.blue_mask_a   = mask_a;
    res.red_mask_b    = mask_b;
    res.green_mask_b  = mask_b;
    res.blue_mask_b   = mask_b;
    res.active_col    = col;
    res.col_advance   = adv;
    res.col_start_bit = start;
    return res;
  endfunction

  function automatic dir_row_t mk_row(in_item_t it, int unsigned reps = 1, bit typed = 1'b0,
                                      out_item_t res = '0);
    dir_row_t row;
    row.item = it;
    row.reps = reps;
    row.typed = typed;
    row.res = res;
    return row;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned r;
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      burst_left = $urandom_range(20, 60);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
      errors++;
    end
  endfunction

  // offer one item, hold it until the transfer, then record what it should produce
  task automatic send_item(in_item_t it, bit typed, out_item_t typed_res);
    int unsigned gap;
    out_item_t   res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i <= it;
    do @(posedge clk_i); while (in_stall_o);
    if (predict_masks(it, res)) mask_q.push_back(typed ? typed_res : res);
  endtask

  initial begin
    in_item_t    it;
    logic [31:0] word;
    int unsigned sent;
    int unsigned r;
    rst_ni <= 1'b0;
    in_valid_i <= 1'b0;
    in_i <= '0;
    errors = 0;
    masks_seen = 0;
    burst_left = 0;
    pwm_cnt = 0;
    scan_col = 0;
    foreach (pix_idx[k]) pix_idx[k] = '0;
    foreach (pal_lv[k]) pal_lv[k] = '0;
    foreach (led_on[k]) led_on[k] = '0;

    plan = '{
      // empty palette: every LED is level zero and goes dark in the tick that lit it
      mk_row(mk_tick(), 1, 1'b1, mk_masks(8'h00, 8'h00, 3'd1, 1'b1, 1'b0)),
      mk_row(mk_tick(), 1, 1'b1, mk_masks(8'h00, 8'h00, 3'd1, 1'b0, 1'b0)),
      mk_row(mk_tick(), 1, 1'b1, mk_masks(8'h00, 8'h00, 3'd1, 1'b0, 1'b0)),
      mk_row(mk_tick()),
      mk_row('1),
      mk_row(mk_palette(6'd63, 2'd3, 2'd3, 2'd3)),
      mk_row(mk_palette(6'd21, 2'd1, 2'd2, 2'd3)),
      mk_row(mk_palette(6'd42, 2'd2, 2'd1, 2'd0)),
      mk_row(mk_pixel(1'b0, 3'd2, 3'd7, 6'd63)),
      mk_row(mk_pixel(1'b1, 3'd2, 3'd0, 6'd63)),
      mk_row(mk_pixel(1'b1, 3'd3, 3'd7, 6'd21)),
      mk_row(mk_pixel(1'b0, 3'd3, 3'd0, 6'd42)),
      mk_row(mk_pixel(1'b1, 3'd3, 3'd0, 6'd63)),
      // top-level LEDs stay on for the whole period
      mk_row(mk_tick(), 1, 1'b1, mk_masks(8'h80, 8'h01, 3'd2, 1'b1, 1'b0)),
      mk_row(mk_tick(), 3),
      mk_row(mk_tick(), 4)
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      for (int n = 0; n < plan[i].reps; n++) send_item(plan[i].item, plan[i].typed, plan[i].res);
    end

    sent = 0;
    while (sent < ITEM_COUNT) begin
      word = $urandom;
      it = word[$bits(in_item_t)-1:0];
      r = $urandom_range(0, 99);
      if (r < 55)      it.mode = MODE_TICK;
      else if (r < 80) it.mode = MODE_PIXEL;
      else if (r < 96) it.mode = MODE_PALETTE;
      else             it.mode = MODE_UNUSED;
      if (it.mode != MODE_UNUSED) sent++;
      send_item(it, 1'b0, '0);
    end
    in_valid_i <= 1'b0;

    while (mask_q.size() != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // output side: random stalls, stall-free stretches and one long hold-off
  initial begin
    bit          stall_val;
    int unsigned stall_len;
    int unsigned r;
    out_stall_i <= 1'b0;
    held = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      r = $urandom_range(0, 99);
      if (!held && masks_seen >= 200) begin
        held = 1'b1;
        stall_val = 1'b1;
        stall_len = LONG_HOLD;
      end else if (r < 50) begin
        stall_val = 1'b0;
        stall_len = $urandom_range(1, 2);
      end else if (r < 60) begin
        stall_val = 1'b0;
        stall_len = $urandom_range(30, 60);
      end else if (r < 92) begin
        stall_val = 1'b1;
        stall_len = $urandom_range(1, 3);
      end else begin
        stall_val = 1'b1;
        stall_len = $urandom_range(8, 40);
      end
      out_stall_i <= stall_val;
      repeat (stall_len) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (mask_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %h", $realtime, out_o);
        errors++;
      end else begin
        mask_want = mask_q.pop_front();
        check_field("red_mask_a", mask_want.red_mask_a, out_o.red_mask_a);
        check_field("green_mask_a", mask_want.green_mask_a, out_o.green_mask_a);
        check_field("blue_mask_a", mask_want.blue_mask_a, out_o.blue_mask_a);
        check_field("red_mask_b", mask_want.red_mask_b, out_o.red_mask_b);
        check_field("green_mask_b", mask_want.green_mask_b, out_o.green_mask_b);
        check_field("blue_mask_b", mask_want.blue_mask_b, out_o.blue_mask_b);
        check_field("active_col", mask_want.active_col, out_o.active_col);
        check_field("col_advance", mask_want.col_advance, out_o.col_advance);
        check_field("col_start_bit", mask_want.col_start_bit, out_o.col_start_bit);
        masks_seen++;
      end
    end
  end

endmodule

// ----- filelist.f -----
+incdir+src
src/rmp_pkg.sv
src/rmp_store.sv
src/rgb_matrix_pwm_scanner.sv
sim/rgb_matrix_pwm_scanner_tb.sv
